FILE: rtl/core/rtw_pkg.sv
// Shared constants and types for the rank transform window block.
// Field widths, register codes and reset values; no dependencies.
`default_nettype none

package rtw_pkg;

  localparam int PIX_W      = 8;
  localparam int RANK_W     = 6;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int RAD_W      = 2;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 2;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
  localparam logic [FW_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]  HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } center_t;

endpackage

`default_nettype wire

FILE: rtl/core/rank_transform_window_top.sv
// Rank transform over a square window of a raster pixel stream, with APB registers.
// Line history lives in one synchronous memory; depends on rtw_pkg.
//
// A result passes the stage 1, stage 2 and output registers after its pixel is accepted.
// Throughput: one pixel per clock unless the output stalls, set by one read and one
// write-back per cycle on the line memory. Synchronous reset clears counters, stage
// flags, window and registers to defaults; the line memory is not cleared, needs no pass.
`default_nettype none

module rank_transform_window_top #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [rtw_pkg::ADDR_W-1:0]    paddr,
  input  wire [rtw_pkg::DATA_W-1:0]    pwdata,
  output logic [rtw_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  wire                          pixel_valid,
  output logic                         pixel_ready,
  input  wire [rtw_pkg::PIX_W-1:0]     pixel,
  output logic                         result_valid,
  input  wire                          result_ready,
  output logic [rtw_pkg::RANK_W-1:0]   rank,
  output logic [rtw_pkg::ROW_W-1:0]    center_row,
  output logic [rtw_pkg::COL_W-1:0]    center_col,
  output logic                         frame_last
);
  import rtw_pkg::*;

  localparam int HIST = 2 * MAX_RADIUS;
  localparam int SIDE = 2 * MAX_RADIUS + 1;
  localparam int SW   = $clog2(HIST);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CNTW = $clog2(SIDE + 1);
  localparam int SUMW = $clog2(SIDE * SIDE + 1);
  localparam int MW   = HIST * PIX_W;

  // Configuration registers.
  logic [RAD_W-1:0] win_radius;
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_radius   <= RADIUS_RST;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_RADIUS: win_radius   <= pwdata[RAD_W-1:0];
        REG_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS: prdata = DATA_W'(win_radius);
      REG_WIDTH:  prdata = DATA_W'(frame_width);
      REG_HEIGHT: prdata = DATA_W'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // Effective sizes.
  logic [RW-1:0]   r_eff;
  logic [RW:0]     twice_r;
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;

  always_comb begin
    if (win_radius == '0) r_eff = RW'(1);
    else if (32'(win_radius) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(win_radius);
    if (32'(frame_width) < 32'd3) w_eff = WW'(3);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(frame_width);
    if (frame_height < FH_W'(3)) h_eff = FH_W'(3);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = FH_W'(MAX_HEIGHT);
    else h_eff = frame_height;
  end

  assign twice_r = {r_eff, 1'b0};

  // Handshake and stage movement.
  logic in_fire, s1_fire, s2_move, s2_free, out_free;
  logic s1_valid, s2_valid;

  assign out_free    = !result_valid || result_ready;
  assign s2_move     = s2_valid && out_free;
  assign s2_free     = !s2_valid || out_free;
  assign s1_fire     = s1_valid && s2_free;
  assign pixel_ready = !s1_valid || s2_free;
  assign in_fire     = pixel_valid && pixel_ready;

  // Position counters; slot_cnt tracks the row modulo the history depth.
  logic [ROW_W-1:0] row_cnt;
  logic [CW-1:0]    col_cnt;
  logic [SW-1:0]    slot_cnt;

  logic             col_wrap, row_wrap, end_row;
  logic [FH_W-1:0]  row_a, row_inc;
  logic [SW-1:0]    slot_a, slot_cur, slot_next;
  logic [ROW_W-1:0] r_cur, row_next;
  logic [CW-1:0]    c_cur, col_next;
  logic [WW-1:0]    c_inc;
  logic             emit_cur;
  center_t          meta_cur;

  assign col_wrap = WW'(col_cnt) >= w_eff;
  assign row_a    = col_wrap ? FH_W'(row_cnt) + FH_W'(1) : FH_W'(row_cnt);
  assign slot_a   = col_wrap ? ((slot_cnt == SW'(HIST - 1)) ? '0 : slot_cnt + SW'(1))
                             : slot_cnt;
  assign row_wrap = row_a >= h_eff;
  assign r_cur    = row_wrap ? '0 : row_a[ROW_W-1:0];
  assign slot_cur = row_wrap ? '0 : slot_a;
  assign c_cur    = col_wrap ? '0 : col_cnt;

  assign c_inc    = WW'(c_cur) + WW'(1);
  assign end_row  = c_inc >= w_eff;
  assign row_inc  = FH_W'(r_cur) + FH_W'(1);
  assign col_next = end_row ? '0 : c_inc[CW-1:0];
  assign row_next = !end_row ? r_cur : ((row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0]);
  assign slot_next = !end_row ? slot_cur :
                     ((row_inc >= h_eff || slot_cur == SW'(HIST - 1)) ? '0
                                                                      : slot_cur + SW'(1));

  assign emit_cur      = (FH_W'(r_cur) >= FH_W'(twice_r)) && (WW'(c_cur) >= WW'(twice_r));
  assign meta_cur.row  = r_cur - ROW_W'(r_eff);
  assign meta_cur.col  = COL_W'(c_cur - CW'(r_eff));
  assign meta_cur.last = (FH_W'(r_cur) == h_eff - FH_W'(1)) &&
                         (WW'(c_cur) == w_eff - WW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      slot_cnt <= '0;
    end else if (in_fire) begin
      row_cnt  <= row_next;
      col_cnt  <= col_next;
      slot_cnt <= slot_next;
    end
  end

  // Stage 1: request registered while the line memory is read.
  logic [PIX_W-1:0] s1_pix;
  logic [CW-1:0]    s1_col;
  logic [SW-1:0]    s1_slot;
  logic             s1_emit;
  center_t          s1_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix  <= pixel;
      s1_col  <= c_cur;
      s1_slot <= slot_cur;
      s1_emit <= emit_cur;
      s1_meta <= meta_cur;
    end
  end

  // Line memory: one word per column holds that column of every history row.
  logic [MW-1:0] lmem [MAX_WIDTH];
  logic [MW-1:0] mem_q;
  logic [MW-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q <= lmem[c_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      lmem[s1_col] <= wr_word;
    end
  end

  always_comb begin
    for (int j = 0; j < HIST; j++) begin
      wr_word[j*PIX_W +: PIX_W] = (s1_slot == SW'(j)) ? s1_pix : mem_q[j*PIX_W +: PIX_W];
    end
  end

  // Window registers, indexed by column age then row age.
  logic [PIX_W-1:0] win    [SIDE][SIDE];
  logic [PIX_W-1:0] win_nx [SIDE][SIDE];
  logic [PIX_W-1:0] center;
  logic [CNTW-1:0]  cnt_nx [SIDE];

  always_comb begin
    logic [SW:0] sel;
    sel = '0;
    for (int k = 1; k < SIDE; k++) begin
      win_nx[k] = win[k-1];
    end
    win_nx[0][0] = s1_pix;
    for (int a = 1; a < SIDE; a++) begin
      sel = (SW+1)'(s1_slot) + (SW+1)'(HIST - a);
      if (sel >= (SW+1)'(HIST)) sel = sel - (SW+1)'(HIST);
      win_nx[0][a] = mem_q[sel[SW-1:0]*PIX_W +: PIX_W];
    end
  end

  always_comb begin
    center = '0;
    for (int i = 1; i <= MAX_RADIUS; i++) begin
      if (r_eff == RW'(i)) center = win[i-1][i];
    end
  end

  always_comb begin
    for (int k = 0; k < SIDE; k++) begin
      cnt_nx[k] = '0;
      for (int a = 0; a < SIDE; a++) begin
        if (win_nx[k][a] < center && (RW+1)'(k) <= twice_r && (RW+1)'(a) <= twice_r)
          cnt_nx[k] = cnt_nx[k] + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SIDE; k++) begin
        for (int a = 0; a < SIDE; a++) begin
          win[k][a] <= '0;
        end
      end
    end else if (s1_fire) begin
      win <= win_nx;
    end
  end

  // Stage 2: per-column counts.
  logic [CNTW-1:0] s2_cnt [SIDE];
  center_t         s2_meta;
  logic [SUMW-1:0] rank_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_fire && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_cnt  <= cnt_nx;
      s2_meta <= s1_meta;
    end
  end

  always_comb begin
    rank_sum = '0;
    for (int k = 0; k < SIDE; k++) begin
      rank_sum = rank_sum + SUMW'(s2_cnt[k]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      rank       <= RANK_W'(rank_sum);
      center_row <= s2_meta.row;
      center_col <= s2_meta.col;
      frame_last <= s2_meta.last;
    end
  end

  // A read never meets the write-back of the same column in one cycle.
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    in_fire && s1_fire |-> c_cur != s1_col)
    else $error("line memory read and write-back hit the same column");

  a_emit_reaches_s2: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_emit |=> s2_valid)
    else $error("emitting request did not enter the count stage");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_free |=> s2_valid && $stable(s2_meta))
    else $error("stalled count stage lost its request");

endmodule

`default_nettype wire

FILE: dv/tb_rank_transform_window_top.sv
`timescale 1ns / 100ps
// Self-checking bench for rank_transform_window_top: streams raster frames at several
// window and frame sizes and checks every rank, center and last flag against a local model.
// Depends on rtw_pkg and the top-level RTL only.

module tb_rank_transform_window_top;
  import rtw_pkg::*;

  localparam int HIST_ROWS    = 6;
  localparam int WIN_SIDE     = 7;
  localparam int LINE_LEN     = 1024;
  localparam int LIMIT        = 3000000;
  localparam int SETTLE       = 8;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CALM_ITEMS   = 900;

  typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_EXTREME} fill_mode_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    center_t           ctr;
  } rank_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  wire  [DATA_W-1:0] prdata;
  wire               pready;
  logic              pixel_valid = 1'b0;
  wire               pixel_ready;
  logic [PIX_W-1:0]  pixel = '0;
  wire               result_valid;
  logic              result_ready = 1'b0;
  wire [RANK_W-1:0]  rank;
  wire [ROW_W-1:0]   center_row;
  wire [COL_W-1:0]   center_col;
  wire               frame_last;

  logic [PIX_W-1:0]  hist_mem [HIST_ROWS*LINE_LEN];
  logic [PIX_W-1:0]  win_px [WIN_SIDE][WIN_SIDE];
  int unsigned       row_pos;
  int unsigned       col_pos;
  logic [RAD_W-1:0]  cfg_radius;
  logic [FW_W-1:0]   cfg_width;
  logic [FH_W-1:0]   cfg_height;

  logic [PIX_W-1:0]  pixel_backlog [$];
  rank_result_t      pending_ranks [$];
  int unsigned       queued_items = 0;
  int unsigned       accepted_items = 0;
  int                mismatch_count = 0;
  int                idle_pct = 0;
  bit                calm = 1'b0;
  int                src_gap = 0;
  int                sink_stall = 0;
  int unsigned       cycle_count;

  rank_transform_window_top DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .rank(rank),
    .center_row(center_row),
    .center_col(center_col),
    .frame_last(frame_last)
  );

  always #1 clk = ~clk;

  function automatic int unsigned eff_width();
    if (cfg_width < 3) return 3;
    if (cfg_width > LINE_LEN) return LINE_LEN;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height < 3) return 3;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_height;
  endfunction

  function automatic int unsigned eff_radius();
    if (cfg_radius < 1) return 1;
    return cfg_radius;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advances the local copy of the window by one pixel and queues the rank it causes.
  task automatic predict_rank(input logic [PIX_W-1:0] pix);
    int unsigned w, h, rad, r, c, slot, cnt;
    logic [PIX_W-1:0] mid;
    rank_result_t res;
    w = eff_width();
    h = eff_height();
    rad = eff_radius();
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    slot = r % HIST_ROWS;
    for (int k = WIN_SIDE - 1; k >= 1; k--) begin
      for (int a = 0; a < WIN_SIDE; a++) win_px[k][a] = win_px[k-1][a];
    end
    win_px[0][0] = pix;
    for (int a = 1; a <= HIST_ROWS; a++) begin
      win_px[0][a] = hist_mem[((slot + HIST_ROWS - a) % HIST_ROWS) * LINE_LEN + c];
    end
    hist_mem[slot * LINE_LEN + c] = pix;
    if (r >= 2 * rad && c >= 2 * rad) begin
      mid = win_px[rad][rad];
      cnt = 0;
      for (int k = 0; k <= 2 * rad; k++) begin
        for (int a = 0; a <= 2 * rad; a++) begin
          if (win_px[k][a] < mid) cnt++;
        end
      end
      res.rank = cnt[RANK_W-1:0];
      res.ctr.row = ROW_W'(r - rad);
      res.ctr.col = COL_W'(c - rad);
      res.ctr.last = (r == h - 1) && (c == w - 1);
      pending_ranks.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, r, c, n;
    w = eff_width();
    h = eff_height();
    r = row_pos;
    c = col_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    if (r == 0 && c == 0) n = 0;
    else n = (h - r) * w - c;
    return n;
  endfunction

  function automatic logic [PIX_W-1:0] gen_pixel(input fill_mode_t mode);
    case (mode)
      FILL_NARROW:  return PIX_W'($urandom_range(3, 0));
      FILL_EXTREME: return $urandom_range(1, 0) ? 8'hFF : 8'h00;
      default:      return PIX_W'($urandom);
    endcase
  endfunction

  task automatic push_value(input logic [PIX_W-1:0] v);
    pixel_backlog.push_back(v);
    queued_items++;
  endtask

  task automatic push_pixels(input int unsigned n, input fill_mode_t mode);
    for (int unsigned i = 0; i < n; i++) push_value(gen_pixel(mode));
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: cfg_radius = value[RAD_W-1:0];
      REG_WIDTH:  cfg_width = value[FW_W-1:0];
      REG_HEIGHT: cfg_height = value[FH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [DATA_W-1:0] rad, input logic [DATA_W-1:0] wid,
                              input logic [DATA_W-1:0] hgt);
    reg_write(REG_RADIUS, rad);
    reg_write(REG_WIDTH, wid);
    reg_write(REG_HEIGHT, hgt);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (accepted_items != queued_items) @(posedge clk);
    while (pending_ranks.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_ranks.size() != 0) begin
      report_mismatch($sformatf("%0d expected ranks never arrived", pending_ranks.size()));
      pending_ranks.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_result();
    rank_result_t want;
    if (pending_ranks.size() == 0) begin
      report_mismatch($sformatf("unexpected rank %0d at row %0d col %0d",
                                rank, center_row, center_col));
    end else begin
      want = pending_ranks.pop_front();
      if (rank !== want.rank)
        report_mismatch($sformatf("rank %0d, expected %0d at row %0d col %0d",
                                  rank, want.rank, want.ctr.row, want.ctr.col));
      if (center_row !== want.ctr.row)
        report_mismatch($sformatf("center_row %0d, expected %0d", center_row, want.ctr.row));
      if (center_col !== want.ctr.col)
        report_mismatch($sformatf("center_col %0d, expected %0d", center_col, want.ctr.col));
      if (frame_last !== want.ctr.last)
        report_mismatch($sformatf("frame_last %0b, expected %0b at row %0d col %0d",
                                  frame_last, want.ctr.last, want.ctr.row, want.ctr.col));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) begin
        predict_rank(pixel);
        accepted_items++;
      end
      if (!pixel_valid || pixel_ready) begin
        if (!calm && src_gap > 0) begin
          src_gap--;
          pixel_valid <= 1'b0;
        end else if (!calm && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
          src_gap = $urandom_range(16, 0);
          pixel_valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          pixel <= pixel_backlog.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) check_result();
      if (!calm && sink_stall > 0) begin
        sink_stall--;
        result_ready <= 1'b0;
      end else if (!calm && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        sink_stall = $urandom_range(16, 0);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned base, w1, rows, part;
    fill_mode_t mode;
    for (int i = 0; i < HIST_ROWS * LINE_LEN; i++) hist_mem[i] = '0;
    for (int k = 0; k < WIN_SIDE; k++) begin
      for (int a = 0; a < WIN_SIDE; a++) win_px[k][a] = '0;
    end
    row_pos = 0;
    col_pos = 0;
    cfg_radius = RADIUS_RST;
    cfg_width = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest frame with the reset radius: a bright center above a dark border.
    reg_write(REG_WIDTH, 3);
    reg_write(REG_HEIGHT, 3);
    for (int i = 0; i < 9; i++) push_value(i == 4 ? 8'hFF : 8'h00);
    wait_idle();

    // Zero radius and undersized frame saturate to a 3x3 frame; a flat image ranks zero.
    set_geometry(0, 0, 0);
    for (int i = 0; i < 9; i++) push_value(8'h5A);
    wait_idle();

    // Frame narrower than the window yields nothing.
    set_geometry(2, 3, 3);
    push_pixels(9, FILL_RANDOM);
    wait_idle();

    // Oversized height saturates; after three rows the height is cut to four and the frame run out.
    idle_pct = 5;
    set_geometry(1, 5, 8191);
    push_pixels(15, FILL_RANDOM);
    wait_idle();
    reg_write(REG_HEIGHT, 4);
    push_pixels(pixels_to_frame_end(), FILL_RANDOM);
    wait_idle();

    base = queued_items;
    while (queued_items - base < RANDOM_ITEMS) begin
      calm = (queued_items - base >= CALM_ITEMS);
      case ($urandom_range(3, 0))
        0: idle_pct = 0;
        1: idle_pct = 5;
        2: idle_pct = 15;
        default: idle_pct = 30;
      endcase
      if ($urandom_range(3, 0) == 0) mode = fill_mode_t'($urandom_range(2, 1));
      else mode = FILL_RANDOM;
      if ($urandom_range(5, 0) == 0) begin
        // Stop inside a frame, shrink the rows, then run out the frame.
        w1 = $urandom_range(24, 8);
        set_geometry($urandom_range(3, 0), w1, $urandom_range(12, 3));
        rows = $urandom_range(eff_height() - 1, 0);
        part = $urandom_range(w1 - 1, 1);
        push_pixels(rows * w1 + part, mode);
        wait_idle();
        reg_write(REG_WIDTH, $urandom_range(w1, 0));
        push_pixels(pixels_to_frame_end(), mode);
      end else begin
        if ($urandom_range(7, 0) == 0) w1 = $urandom_range(80, 25);
        else w1 = $urandom_range(24, 0);
        set_geometry($urandom_range(3, 0), w1, $urandom_range(12, 0));
        push_pixels($urandom_range(2, 1) * eff_width() * eff_height(), mode);
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
